// File: sv/biquad_iir_filter_unit_defines.svh
// Assertion macros used by the checker of this block.
`ifndef BIQUAD_IIR_FILTER_UNIT_DEFINES_SVH
`define BIQUAD_IIR_FILTER_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define BQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define BQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bq_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int COEF_WIDTH         = 32;
  // Feedback history keeps this many fraction bits beyond a sample.
  localparam int FB_EXTRA           = 8;
  localparam int CFG_IDX_WIDTH      = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: sv/bq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bq_in_if
  import bq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// File: sv/bq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bq_out_if
  import bq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: sv/bq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One tap of the filter: a delay register that hands its value to the next
// tap, and the product of the stored value with the tap coefficient.
module bq_cell
  import bq_pkg::*;
#(
  parameter int DW = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic signed [DW-1:0]           din,
  input  logic signed [COEF_WIDTH-1:0]   coef,
  output logic signed [DW-1:0]           dout,
  output logic signed [DW+COEF_WIDTH-1:0] prod
);

  localparam int PW = DW + COEF_WIDTH;

  logic signed [DW-1:0] d_r;
  logic signed [DW-1:0] d_nxt;

  always_comb begin
    d_nxt = en ? din : d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else begin
      d_r <= d_nxt;
    end
  end

  assign dout = d_r;
  assign prod = PW'(d_r) * PW'(coef);

endmodule

`default_nettype wire

// File: sv/biquad_iir_filter_unit.sv
// Biquad IIR filter, direct form I, fixed point.
// Input channel in_ch carries one signed sample per transfer; output channel
// out_ch carries one filtered sample per input, in order. Both use
// valid/ready; a transfer happens on a clock edge with both high.
// Coefficients b0, b1, b2, a1, a2 (signed, COEF_FRAC_BITS fraction bits) are
// written through cfg_we/cfg_idx/cfg_wdata; the user writes them only while the
// filter is idle, which the block does not enforce; an index beyond a2 is ignored.
// A sample accepted into the tap register x0 is filtered from there into the
// output register and presented on out_ch. Throughput: one sample per cycle
// while the receiver keeps ready high. The limit is the feedback loop: the two
// feedback products, the sum and the rounding to the new feedback value are
// combinational between the feedback registers.
// Reset (rst_n low at a clock edge) clears the sample history, the feedback
// history, both valid flags, and loads b0 = 1.0 and all other coefficients 0.
// When the receiver stalls, the finished sample waits in the output register
// and one more sample is still taken into the tap chain; after that in_ch
// ready drops until the output transfer completes.
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_filter_unit
  import bq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  bq_in_if.sink                    in_ch,
  bq_out_if.source                 out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx,
  input  logic [COEF_WIDTH-1:0]    cfg_wdata
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int CF  = COEF_FRAC_BITS;
  localparam int YW  = SW + FB_EXTRA;
  localparam int XPW = SW + COEF_WIDTH;
  localparam int YPW = YW + COEF_WIDTH;
  localparam int AW  = YW + COEF_WIDTH + 4;
  localparam int OSH = CF + FB_EXTRA;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) <<< CF;
  localparam logic signed [AW-1:0] Y_RND = AW'(1) <<< (CF - 1);
  localparam logic signed [AW-1:0] O_RND = AW'(1) <<< (OSH - 1);
  localparam logic signed [YW-1:0] Y_MAX = {1'b0, {(YW-1){1'b1}}};
  localparam logic signed [YW-1:0] Y_MIN = {1'b1, {(YW-1){1'b0}}};
  localparam logic signed [SW-1:0] O_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] O_MIN = {1'b1, {(SW-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;

  logic a_valid_r, a_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] sample_out_r, sample_out_nxt;

  logic in_acc, fire;

  logic signed [SW-1:0]  x0, x1;
  logic signed [YW-1:0]  y1;
  logic signed [XPW-1:0] px0, px1, px2;
  logic signed [YPW-1:0] py1, py2;

  logic signed [AW-1:0] ff_w, acc_w, ysum, yq, osum, oq;
  logic                 y_fits, o_fits;
  logic signed [YW-1:0] y_new;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= COEF_ONE;
      coef_b1_r <= '0;
      coef_b2_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_B0:  coef_b0_r <= cfg_wdata;
        REG_B1:  coef_b1_r <= cfg_wdata;
        REG_B2:  coef_b2_r <= cfg_wdata;
        REG_A1:  coef_a1_r <= cfg_wdata;
        REG_A2:  coef_a2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The tap chain holds the newest sample while it waits to be filtered.
  assign fire         = a_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !a_valid_r || fire;
  assign in_acc       = in_ch.valid && in_ch.ready;

  bq_cell #(.DW(SW)) u_x0 (
    .clk(clk), .rst_n(rst_n), .en(in_acc), .din(in_ch.sample_in),
    .coef(coef_b0_r), .dout(x0), .prod(px0)
  );
  bq_cell #(.DW(SW)) u_x1 (
    .clk(clk), .rst_n(rst_n), .en(in_acc), .din(x0),
    .coef(coef_b1_r), .dout(x1), .prod(px1)
  );
  bq_cell #(.DW(SW)) u_x2 (
    .clk(clk), .rst_n(rst_n), .en(in_acc), .din(x1),
    .coef(coef_b2_r), .dout(), .prod(px2)
  );

  bq_cell #(.DW(YW)) u_y1 (
    .clk(clk), .rst_n(rst_n), .en(fire), .din(y_new),
    .coef(coef_a1_r), .dout(y1), .prod(py1)
  );
  bq_cell #(.DW(YW)) u_y2 (
    .clk(clk), .rst_n(rst_n), .en(fire), .din(y1),
    .coef(coef_a2_r), .dout(), .prod(py2)
  );

  // Exact accumulation, then two independent round-half-up and saturate steps.
  always_comb begin
    ff_w   = AW'(px0) + AW'(px1) + AW'(px2);
    acc_w  = (ff_w <<< FB_EXTRA) - AW'(py1) - AW'(py2);

    ysum   = acc_w + Y_RND;
    yq     = ysum >>> CF;
    y_fits = (&yq[AW-1:YW-1]) || !(|yq[AW-1:YW-1]);
    y_new  = y_fits ? yq[YW-1:0] : (yq[AW-1] ? Y_MIN : Y_MAX);

    osum   = acc_w + O_RND;
    oq     = osum >>> OSH;
    o_fits = (&oq[AW-1:SW-1]) || !(|oq[AW-1:SW-1]);
    sample_out_nxt = sample_out_r;
    if (fire) begin
      sample_out_nxt = o_fits ? oq[SW-1:0] : (oq[AW-1] ? O_MIN : O_MAX);
    end

    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
    end else if (fire) begin
      a_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_out_r <= sample_out_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = sample_out_r;

endmodule

`default_nettype wire

// File: sv/bq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "biquad_iir_filter_unit_defines.svh"

module bq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  `BQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "output valid dropped before its transfer")
  `BQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")
  `BQ_ASSERT(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready |=> out_valid, "accepted sample not delivered on time")
  `BQ_ASSERT(a_ready_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled while output is empty")

endmodule

bind biquad_iir_filter_unit bq_checker u_bq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready)
);

`default_nettype wire
